/* rtl/calendar_clock_counter_macros.svh */
// assertion macros for the calendar clock counter
`ifndef CALENDAR_CLOCK_COUNTER_MACROS_SVH
`define CALENDAR_CLOCK_COUNTER_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define CCC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: check failed");

// antecedent in one cycle implies consequent in the next
`define CCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`else

`define CCC_ASSERT(label, clk, rst_n, prop)
`define CCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/ccc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ccc_pkg;

	// datapath width of the shared unit, wide enough for a day in ms
	localparam int DW = 27;

	localparam int MS_PER_DAY     = 86400000;
	localparam int DAYS_PER_CENT  = 36525;
	localparam int DAYS_PER_QUAD  = 1461;
	localparam int MS_PER_HOUR    = 3600000;
	localparam int MS_PER_MINUTE  = 60000;
	localparam int MS_PER_SECOND  = 1000;
	localparam int DAYS_LEAP_YEAR = 366;
	localparam int DAYS_YEAR      = 365;

	// quotient bits of each restoring division
	localparam int QUAD_BITS = 5;
	localparam int HOUR_BITS = 5;
	localparam int MIN_BITS  = 6;
	localparam int SEC_BITS  = 6;

	localparam logic [6:0] YEAR_MAX   = 7'd99;
	localparam logic [3:0] MONTH_MAX  = 4'd12;
	localparam logic [3:0] MONTH_MIN  = 4'd1;
	localparam logic [4:0] DAY_MIN    = 5'd1;
	localparam logic [4:0] HOUR_MAX   = 5'd23;
	localparam logic [5:0] MINSEC_MAX = 6'd59;
	localparam logic [9:0] MS_MAX     = 10'd999;

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_LOAD = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [9:0] millisecond;
	} load_t;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [9:0] millisecond;
	} time_t;

	typedef struct packed {
		logic  start;
		logic  ack;
		load_t ld;
	} seq_cmd_t;

	typedef struct packed {
		logic idle;
		logic done;
	} seq_stat_t;

	typedef struct packed {
		logic          sub;
		logic [DW-1:0] a;
		logic [DW-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [DW-1:0] res;
		logic          ge;
	} alu_rsp_t;

	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
		logic [4:0] len;
		case (m) inside
			4'd2:                   len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                len = 5'd31;
		endcase
		return len;
	endfunction

	// days in the year before the first of month m
	function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
		logic [8:0] base;
		case (m)
			4'd1:    base = 9'd0;
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		return base + ((leap && m > 4'd2) ? 9'd1 : 9'd0);
	endfunction

	// days from 2000-01-01 to the first of january of year y
	function automatic logic [15:0] year_start(input logic [6:0] y);
		logic [15:0] quad_days;
		logic [15:0] rest;
		quad_days = 16'(32'(y[6:2]) * DAYS_PER_QUAD);
		if (y[1:0] == 2'd0) begin
			rest = 16'd0;
		end else begin
			rest = 16'(DAYS_LEAP_YEAR + (32'(y[1:0]) - 1) * DAYS_YEAR);
		end
		return quad_days + rest;
	endfunction

	function automatic logic [DW-1:0] hour_ms(input logic [4:0] h);
		return DW'(32'(h) * MS_PER_HOUR);
	endfunction

	function automatic logic [DW-1:0] minute_ms(input logic [5:0] mi);
		return DW'(32'(mi) * MS_PER_MINUTE);
	endfunction

	function automatic logic [DW-1:0] second_ms(input logic [5:0] s);
		return DW'(32'(s) * MS_PER_SECOND);
	endfunction

endpackage

`default_nettype wire

/* rtl/ccc_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ccc_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [6:0] load_year;
	logic [3:0] load_month;
	logic [4:0] load_day;
	logic [4:0] load_hour;
	logic [5:0] load_minute;
	logic [5:0] load_second;
	logic [9:0] load_millisecond;

	modport source (
		output valid, mode, load_year, load_month, load_day, load_hour,
			load_minute, load_second, load_millisecond,
		input  ready
	);

	modport sink (
		input  valid, mode, load_year, load_month, load_day, load_hour,
			load_minute, load_second, load_millisecond,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/ccc_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ccc_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] year;
	logic [3:0] month;
	logic [4:0] day;
	logic [4:0] hour;
	logic [5:0] minute;
	logic [5:0] second;
	logic [9:0] millisecond;

	modport source (
		output valid, year, month, day, hour, minute, second, millisecond,
		input  ready
	);

	modport sink (
		input  valid, year, month, day, hour, minute, second, millisecond,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/ccc_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

// shared add / compare-subtract unit
module ccc_alu (
	input  ccc_pkg::alu_req_t req,
	output ccc_pkg::alu_rsp_t rsp
);

	logic [ccc_pkg::DW:0] sum;

	always_comb begin
		sum = {1'b0, req.a}
			+ {1'b0, (req.sub ? ~req.b : req.b)}
			+ (ccc_pkg::DW + 1)'(req.sub);
		rsp.res = sum[ccc_pkg::DW-1:0];
		// carry out of a - b means a >= b
		rsp.ge  = sum[ccc_pkg::DW];
	end

endmodule

`default_nettype wire

/* rtl/ccc_seq.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "calendar_clock_counter_macros.svh"

module ccc_seq (
	input  wire                clk,
	input  wire                arst_n,
	input  ccc_pkg::seq_cmd_t  cmd,
	output ccc_pkg::seq_stat_t stat,
	output ccc_pkg::time_t     res
);

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_TICK_INC  = 5'd1;
	localparam logic [4:0] S_TICK_WRAP = 5'd2;
	localparam logic [4:0] S_DAY_INC   = 5'd3;
	localparam logic [4:0] S_DAY_WRAP  = 5'd4;
	localparam logic [4:0] S_LD_DAYS0  = 5'd5;
	localparam logic [4:0] S_LD_DAYS1  = 5'd6;
	localparam logic [4:0] S_LD_MS0    = 5'd7;
	localparam logic [4:0] S_LD_MS1    = 5'd8;
	localparam logic [4:0] S_LD_MS2    = 5'd9;
	localparam logic [4:0] S_DEC_INIT  = 5'd10;
	localparam logic [4:0] S_QUAD      = 5'd11;
	localparam logic [4:0] S_YEAR      = 5'd12;
	localparam logic [4:0] S_MONTH     = 5'd13;
	localparam logic [4:0] S_HOUR      = 5'd14;
	localparam logic [4:0] S_MIN       = 5'd15;
	localparam logic [4:0] S_SEC       = 5'd16;
	localparam logic [4:0] S_DONE      = 5'd17;

	localparam int DW = ccc_pkg::DW;

	logic [4:0]    state_q;
	logic [15:0]   days_q;
	logic [DW-1:0] msd_q;
	logic [DW-1:0] rem_q;
	logic [2:0]    bit_q;
	logic [5:0]    quo_q;
	logic [1:0]    yoff_q;
	logic          leap_q;
	logic [3:0]    month_q;
	logic [6:0]    year_q;
	logic [4:0]    day_q;
	logic [4:0]    hour_q;
	logic [5:0]    minute_q;
	logic [5:0]    second_q;
	ccc_pkg::load_t ld_q;

	ccc_pkg::alu_req_t alu_req;
	ccc_pkg::alu_rsp_t alu_rsp;

	logic          leap_ld;
	logic [DW-1:0] rem_n;
	logic [5:0]    quo_n;
	logic          month_step;

	ccc_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign leap_ld    = (ld_q.year[1:0] == 2'd0);
	assign rem_n      = alu_rsp.ge ? alu_rsp.res : rem_q;
	assign quo_n      = {quo_q[4:0], alu_rsp.ge};
	assign month_step = (month_q < ccc_pkg::MONTH_MAX) && alu_rsp.ge;

	// operand selection for the shared unit
	always_comb begin
		alu_req = '0;
		case (state_q)
			S_TICK_INC: begin
				alu_req.a = msd_q;
				alu_req.b = DW'(1);
			end
			S_TICK_WRAP: begin
				alu_req.sub = 1'b1;
				alu_req.a   = rem_q;
				alu_req.b   = DW'(ccc_pkg::MS_PER_DAY);
			end
			S_DAY_INC: begin
				alu_req.a = DW'(days_q);
				alu_req.b = DW'(1);
			end
			S_DAY_WRAP: begin
				alu_req.sub = 1'b1;
				alu_req.a   = rem_q;
				alu_req.b   = DW'(ccc_pkg::DAYS_PER_CENT);
			end
			S_LD_DAYS0: begin
				alu_req.a = DW'(ccc_pkg::year_start(ld_q.year));
				alu_req.b = DW'(ccc_pkg::month_start(leap_ld, ld_q.month));
			end
			S_LD_DAYS1: begin
				alu_req.a = rem_q;
				alu_req.b = DW'(ld_q.day) - DW'(1);
			end
			S_LD_MS0: begin
				alu_req.a = ccc_pkg::hour_ms(ld_q.hour);
				alu_req.b = ccc_pkg::minute_ms(ld_q.minute);
			end
			S_LD_MS1: begin
				alu_req.a = rem_q;
				alu_req.b = ccc_pkg::second_ms(ld_q.second);
			end
			S_LD_MS2: begin
				alu_req.a = rem_q;
				alu_req.b = DW'(ld_q.millisecond);
			end
			S_QUAD: begin
				alu_req.sub = 1'b1;
				alu_req.a   = rem_q;
				alu_req.b   = DW'(ccc_pkg::DAYS_PER_QUAD) << bit_q;
			end
			S_YEAR: begin
				alu_req.sub = 1'b1;
				alu_req.a   = rem_q;
				alu_req.b   = (yoff_q == 2'd0) ? DW'(ccc_pkg::DAYS_LEAP_YEAR)
					: DW'(ccc_pkg::DAYS_YEAR);
			end
			S_MONTH: begin
				alu_req.sub = 1'b1;
				alu_req.a   = rem_q;
				alu_req.b   = DW'(ccc_pkg::month_len(leap_q, month_q));
			end
			S_HOUR: begin
				alu_req.sub = 1'b1;
				alu_req.a   = rem_q;
				alu_req.b   = DW'(ccc_pkg::MS_PER_HOUR) << bit_q;
			end
			S_MIN: begin
				alu_req.sub = 1'b1;
				alu_req.a   = rem_q;
				alu_req.b   = DW'(ccc_pkg::MS_PER_MINUTE) << bit_q;
			end
			S_SEC: begin
				alu_req.sub = 1'b1;
				alu_req.a   = rem_q;
				alu_req.b   = DW'(ccc_pkg::MS_PER_SECOND) << bit_q;
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	// sequencer and clock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			days_q  <= '0;
			msd_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						state_q <= (cmd.ld.mode == ccc_pkg::MODE_LOAD) ? S_LD_DAYS0
							: S_TICK_INC;
					end
				end
				S_TICK_INC: state_q <= S_TICK_WRAP;
				S_TICK_WRAP: begin
					if (alu_rsp.ge) begin
						msd_q   <= '0;
						state_q <= S_DAY_INC;
					end else begin
						msd_q   <= rem_q;
						state_q <= S_DEC_INIT;
					end
				end
				S_DAY_INC: state_q <= S_DAY_WRAP;
				S_DAY_WRAP: begin
					days_q  <= alu_rsp.ge ? '0 : rem_q[15:0];
					state_q <= S_DEC_INIT;
				end
				S_LD_DAYS0: state_q <= S_LD_DAYS1;
				S_LD_DAYS1: begin
					days_q  <= alu_rsp.res[15:0];
					state_q <= S_LD_MS0;
				end
				S_LD_MS0: state_q <= S_LD_MS1;
				S_LD_MS1: state_q <= S_LD_MS2;
				S_LD_MS2: begin
					msd_q   <= alu_rsp.res;
					state_q <= S_DEC_INIT;
				end
				S_DEC_INIT: state_q <= S_QUAD;
				S_QUAD: begin
					if (bit_q == 3'd0) begin
						state_q <= S_YEAR;
					end
				end
				S_YEAR: begin
					if (!alu_rsp.ge) begin
						state_q <= S_MONTH;
					end
				end
				S_MONTH: begin
					if (!month_step) begin
						state_q <= S_HOUR;
					end
				end
				S_HOUR: begin
					if (bit_q == 3'd0) begin
						state_q <= S_MIN;
					end
				end
				S_MIN: begin
					if (bit_q == 3'd0) begin
						state_q <= S_SEC;
					end
				end
				S_SEC: begin
					if (bit_q == 3'd0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (cmd.ack) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers of the decode
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd.start) begin
					ld_q <= cmd.ld;
				end
			end
			S_TICK_INC, S_DAY_INC, S_LD_DAYS0, S_LD_MS0, S_LD_MS1: begin
				rem_q <= alu_rsp.res;
			end
			S_DEC_INIT: begin
				rem_q <= DW'(days_q);
				bit_q <= 3'(ccc_pkg::QUAD_BITS - 1);
				quo_q <= '0;
			end
			S_QUAD: begin
				rem_q  <= rem_n;
				quo_q  <= quo_n;
				bit_q  <= bit_q - 3'd1;
				yoff_q <= 2'd0;
			end
			S_YEAR: begin
				if (alu_rsp.ge) begin
					rem_q  <= alu_rsp.res;
					yoff_q <= yoff_q + 2'd1;
				end else begin
					year_q  <= {quo_q[4:0], yoff_q};
					leap_q  <= (yoff_q == 2'd0);
					month_q <= ccc_pkg::MONTH_MIN;
				end
			end
			S_MONTH: begin
				if (month_step) begin
					rem_q   <= alu_rsp.res;
					month_q <= month_q + 4'd1;
				end else begin
					day_q <= rem_q[4:0] + 5'd1;
					rem_q <= msd_q;
					bit_q <= 3'(ccc_pkg::HOUR_BITS - 1);
					quo_q <= '0;
				end
			end
			S_HOUR: begin
				rem_q <= rem_n;
				if (bit_q == 3'd0) begin
					hour_q <= quo_n[4:0];
					bit_q  <= 3'(ccc_pkg::MIN_BITS - 1);
					quo_q  <= '0;
				end else begin
					quo_q <= quo_n;
					bit_q <= bit_q - 3'd1;
				end
			end
			S_MIN: begin
				rem_q <= rem_n;
				if (bit_q == 3'd0) begin
					minute_q <= quo_n;
					bit_q    <= 3'(ccc_pkg::SEC_BITS - 1);
					quo_q    <= '0;
				end else begin
					quo_q <= quo_n;
					bit_q <= bit_q - 3'd1;
				end
			end
			S_SEC: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				bit_q <= bit_q - 3'd1;
				if (bit_q == 3'd0) begin
					second_q <= quo_n;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_DONE);

	assign res.year        = year_q;
	assign res.month       = month_q;
	assign res.day         = day_q;
	assign res.hour        = hour_q;
	assign res.minute      = minute_q;
	assign res.second      = second_q;
	assign res.millisecond = rem_q[9:0];

	`CCC_ASSERT(a_msd_range, clk, arst_n, msd_q < DW'(ccc_pkg::MS_PER_DAY))
	`CCC_ASSERT(a_done_fields, clk, arst_n, stat.done |-> (day_q != 5'd0 && hour_q <= 5'd23))
	`CCC_ASSERT_NEXT(a_start_leaves_idle, clk, arst_n, stat.idle && cmd.start, !stat.idle)

endmodule

`default_nettype wire

/* rtl/calendar_clock_counter.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  word
// req      in         mode (0 tick, 1 load), load_year .. load_millisecond
// rsp      out        year, month, day, hour, minute, second, millisecond
//
// one word at a time; the shared 27-bit add / compare-subtract unit steps the
// restoring divisions and the month walk for each word; a new word is taken in
// the cycle after the result moves to the output register, even while rsp is
// stalled
// reset clears the clock to 2000-01-01 00:00:00.000

`include "calendar_clock_counter_macros.svh"

module calendar_clock_counter (
	input  wire         clk,
	input  wire         arst_n,
	ccc_in_if.sink      req,
	ccc_out_if.source   rsp
);

	ccc_pkg::seq_cmd_t  cmd;
	ccc_pkg::seq_stat_t stat;
	ccc_pkg::time_t     seq_res;
	ccc_pkg::time_t     out_q;
	logic               rsp_valid_q;

	// clamped load fields
	logic [6:0] y_c;
	logic [3:0] m_c;
	logic [4:0] d_c;
	logic [4:0] d_len;
	logic       leap_c;

	ccc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.res    (seq_res)
	);

	// only take a word while the sequencer is free
	assign req.ready = stat.idle;

	// clamp out-of-range load fields, day against the month length
	always_comb begin
		y_c = (req.load_year > ccc_pkg::YEAR_MAX) ? ccc_pkg::YEAR_MAX : req.load_year;
		if (req.load_month > ccc_pkg::MONTH_MAX) begin
			m_c = ccc_pkg::MONTH_MAX;
		end else if (req.load_month == 4'd0) begin
			m_c = ccc_pkg::MONTH_MIN;
		end else begin
			m_c = req.load_month;
		end
		leap_c = (y_c[1:0] == 2'd0);
		d_len  = ccc_pkg::month_len(leap_c, m_c);
		d_c    = (req.load_day == 5'd0) ? ccc_pkg::DAY_MIN : req.load_day;
		if (d_c > d_len) begin
			d_c = d_len;
		end
	end

	always_comb begin
		cmd.start          = req.valid && req.ready;
		// hand the result over when the output register is free
		cmd.ack            = stat.done && (!rsp_valid_q || rsp.ready);
		cmd.ld.mode        = req.mode;
		cmd.ld.year        = y_c;
		cmd.ld.month       = m_c;
		cmd.ld.day         = d_c;
		cmd.ld.hour        = (req.load_hour > ccc_pkg::HOUR_MAX) ? ccc_pkg::HOUR_MAX
			: req.load_hour;
		cmd.ld.minute      = (req.load_minute > ccc_pkg::MINSEC_MAX) ? ccc_pkg::MINSEC_MAX
			: req.load_minute;
		cmd.ld.second      = (req.load_second > ccc_pkg::MINSEC_MAX) ? ccc_pkg::MINSEC_MAX
			: req.load_second;
		cmd.ld.millisecond = (req.load_millisecond > ccc_pkg::MS_MAX) ? ccc_pkg::MS_MAX
			: req.load_millisecond;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.ack) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ack) begin
			out_q <= seq_res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.year        = out_q.year;
	assign rsp.month       = out_q.month;
	assign rsp.day         = out_q.day;
	assign rsp.hour        = out_q.hour;
	assign rsp.minute      = out_q.minute;
	assign rsp.second      = out_q.second;
	assign rsp.millisecond = out_q.millisecond;

	`CCC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready)
	`CCC_ASSERT_NEXT(a_done_holds, clk, arst_n, stat.done && rsp_valid_q && !rsp.ready, stat.done)
	`CCC_ASSERT(a_valid_from_done, clk, arst_n, $rose(rsp_valid_q) |-> $past(stat.done))

endmodule

`default_nettype wire
